>>> hdl/bpa_pkg.sv
// Shared types and constants for the bitmap page allocator.
// No dependencies; imported by every module of the block except bpa_ram.
package bpa_pkg;

	localparam int unsigned FRAME_W       = 52;
	localparam int unsigned STATUS_W      = 3;
	localparam int unsigned WIU_W         = 7;
	localparam int unsigned BITS_PER_WORD = 64;
	localparam int unsigned BIT_W         = 6;
	localparam int unsigned DEF_MAX_WORDS = 64;
	localparam int unsigned REG_IDX_W     = 2;
	localparam int unsigned CFG_DATA_W    = 52;
	localparam logic [WIU_W-1:0] WIU_RESET = 7'd64;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_e;

	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_DUMMY     = 3'd1,
		ST_EXHAUSTED = 3'd2,
		ST_FREED     = 3'd3,
		ST_REJECTED  = 3'd4
	} status_e;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_WORDS_IN_USE = 2'd0,
		REG_BASE_FRAME   = 2'd1,
		REG_DUMMY_FRAME  = 2'd2,
		REG_DUMMY_VALID  = 2'd3
	} reg_idx_e;

	typedef struct packed {
		logic               cmd;
		logic [FRAME_W-1:0] page_frame;
	} req_t;

	typedef struct packed {
		logic [FRAME_W-1:0]  result_frame;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// controller -> datapath
	typedef struct packed {
		logic clr_we;
		logic accept;
		logic mod_step;
		logic addr_load;
		logic rd_en;
		logic wr_en;
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clr_last;
		logic need_mod;
		logic mod_last;
		logic hit;
	} dp_stat_t;

endpackage

>>> hdl/bpa_ram.sv
// Generic simple dual-port RAM, one write and one registered read per cycle.
// Stand-alone; no package needed.
module bpa_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 64
) (
	input  logic                                        clk,
	input  logic                                        we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                            wdata,
	input  logic                                        re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/bpa_ctrl.sv
// Sequencer for the allocator: clearing pass, hint reduction, search, read, write.
// Depends on bpa_pkg for the command and status structs.
module bpa_ctrl
	import bpa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output ctl_cmd_t cmd,
	input  dp_stat_t st
);

	typedef enum logic [5:0] {
		S_CLEAR = 6'b000001,
		S_IDLE  = 6'b000010,
		S_MOD   = 6'b000100,
		S_ADDR  = 6'b001000,
		S_RD    = 6'b010000,
		S_WR    = 6'b100000
	} state_t;

	state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr_we = 1'b1;
				if (st.clr_last) begin
					state_nxt = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					cmd.accept = 1'b1;
					state_nxt  = st.need_mod ? S_MOD : S_ADDR;
				end
			end
			S_MOD: begin
				cmd.mod_step = 1'b1;
				if (st.mod_last) begin
					state_nxt = S_ADDR;
				end
			end
			S_ADDR: begin
				cmd.addr_load = 1'b1;
				state_nxt     = st.hit ? S_RD : S_IDLE;
			end
			S_RD: begin
				cmd.rd_en = 1'b1;
				state_nxt = S_WR;
			end
			S_WR: begin
				cmd.wr_en = 1'b1;
				state_nxt = S_IDLE;
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> hdl/bpa_dp.sv
// Datapath: config registers, full-word flags, hint, bitmap RAM, result register.
// Depends on bpa_pkg and bpa_ram.
module bpa_dp
	import bpa_pkg::*;
#(
	parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  req_t                  req,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              st,
	input  logic                  cfg_we,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output logic                  done,
	output rsp_t                  rsp
);

	localparam int unsigned WIDX = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
	localparam int unsigned BW   = (WIDX > 1) ? $clog2(WIDX) : 1;
	localparam int unsigned HI_W = FRAME_W - BIT_W;

	// first set bit of a word-flag vector: {found, index}
	function automatic logic [WIDX:0] first_set(input logic [MAX_WORDS-1:0] v);
		logic [WIDX:0] r;
		r = '0;
		for (int i = int'(MAX_WORDS) - 1; i >= 0; i--) begin
			if (v[i]) begin
				r = {1'b1, WIDX'(i)};
			end
		end
		return r;
	endfunction

	function automatic logic [BIT_W-1:0] low_zero(input logic [BITS_PER_WORD-1:0] w);
		logic [BIT_W-1:0] r;
		r = BIT_W'(BITS_PER_WORD - 1);
		for (int i = int'(BITS_PER_WORD) - 1; i >= 0; i--) begin
			if (!w[i]) begin
				r = BIT_W'(i);
			end
		end
		return r;
	endfunction

	// configuration
	logic [WIU_W-1:0]   wiu_q;
	logic [FRAME_W-1:0] base_q;
	logic [FRAME_W-1:0] dummy_q;
	logic               dummy_vld_q;

	// control state
	logic [MAX_WORDS-1:0] full_q;
	logic [WIDX-1:0]      hint_q;
	logic [WIDX-1:0]      clr_q;
	logic [WIDX-1:0]      start_q;
	logic [WIU_W-1:0]     rem_q;
	logic [BW-1:0]        mbit_q;
	logic                 done_q;

	// payload
	req_t             req_q;
	logic [WIDX-1:0]  idx_q;
	logic [BIT_W-1:0] bit_q;
	rsp_t             rsp_q;

	logic [WIU_W-1:0]         n_eff;
	logic [MAX_WORDS-1:0]     free_vec;
	logic [MAX_WORDS-1:0]     high_vec;
	logic [WIDX:0]            enc_hi;
	logic [WIDX:0]            enc_all;
	logic                     found;
	logic [WIDX-1:0]          enc_idx;
	logic [WIU_W:0]           mod_t;
	logic [WIU_W-1:0]         mod_red;
	logic [FRAME_W-1:0]       off;
	logic                     reject;
	logic                     is_free;
	logic                     hit_c;
	logic [BITS_PER_WORD-1:0] rd_word;
	logic [BITS_PER_WORD-1:0] new_word;
	logic [BIT_W-1:0]         lz;
	logic [BIT_W-1:0]         wr_bit;
	logic                     ram_we;
	logic [WIDX-1:0]          ram_waddr;
	logic [BITS_PER_WORD-1:0] ram_wdata;

	assign n_eff = (32'(wiu_q) > MAX_WORDS) ? WIU_W'(MAX_WORDS) : wiu_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wiu_q       <= WIU_RESET;
			base_q      <= '0;
			dummy_q     <= '0;
			dummy_vld_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_e'(cfg_index))
				REG_WORDS_IN_USE: wiu_q       <= cfg_wdata[WIU_W-1:0];
				REG_BASE_FRAME:   base_q      <= cfg_wdata[FRAME_W-1:0];
				REG_DUMMY_FRAME:  dummy_q     <= cfg_wdata[FRAME_W-1:0];
				REG_DUMMY_VALID:  dummy_vld_q <= cfg_wdata[0];
				default:          wiu_q       <= wiu_q;
			endcase
		end
	end

	// rotating priority search over non-full words in the pool
	always_comb begin
		for (int i = 0; i < int'(MAX_WORDS); i++) begin
			free_vec[i] = !full_q[i] && (32'(i) < 32'(n_eff));
			high_vec[i] = free_vec[i] && (32'(i) >= 32'(start_q));
		end
	end

	assign enc_hi  = first_set(high_vec);
	assign enc_all = first_set(free_vec);
	assign found   = enc_all[WIDX];
	assign enc_idx = enc_hi[WIDX] ? enc_hi[WIDX-1:0] : enc_all[WIDX-1:0];

	// one restoring step of hint mod n per cycle, MSB first
	assign mod_t   = {rem_q, hint_q[mbit_q]};
	assign mod_red = (mod_t >= (WIU_W+1)'(n_eff)) ? WIU_W'(mod_t - (WIU_W+1)'(n_eff))
	                                               : WIU_W'(mod_t);

	// free range check
	assign off     = req_q.page_frame - base_q;
	assign reject  = (req_q.page_frame < base_q) || (off[FRAME_W-1:BIT_W] >= HI_W'(n_eff));
	assign is_free = (req_q.cmd == CMD_FREE);
	assign hit_c   = is_free ? !reject : found;

	assign st.clr_last = (32'(clr_q) == MAX_WORDS - 1);
	assign st.need_mod = (req.cmd == CMD_ALLOC) && (n_eff != '0)
	                     && (32'(hint_q) >= 32'(n_eff));
	assign st.mod_last = (mbit_q == '0);
	assign st.hit      = hit_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q   <= '0;
			hint_q  <= '0;
			start_q <= '0;
			rem_q   <= '0;
			mbit_q  <= '0;
			full_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.clr_we) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.accept) begin
				start_q <= hint_q;
				rem_q   <= '0;
				mbit_q  <= BW'(WIDX - 1);
			end
			if (cmd.mod_step) begin
				rem_q  <= mod_red;
				mbit_q <= mbit_q - 1'b1;
				if (st.mod_last) begin
					start_q <= WIDX'(mod_red);
				end
			end
			if (cmd.addr_load && !hit_c) begin
				done_q <= 1'b1;
			end
			if (cmd.wr_en) begin
				done_q         <= 1'b1;
				full_q[idx_q] <= &new_word;
				if (!is_free) begin
					hint_q <= idx_q;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q <= req;
		end
		if (cmd.addr_load) begin
			idx_q <= is_free ? off[BIT_W +: WIDX] : enc_idx;
			bit_q <= off[BIT_W-1:0];
		end
	end

	// word update
	assign lz       = low_zero(rd_word);
	assign wr_bit   = is_free ? bit_q : lz;
	assign new_word = is_free ? (rd_word & ~(BITS_PER_WORD'(1) << wr_bit))
	                          : (rd_word | (BITS_PER_WORD'(1) << wr_bit));

	always_ff @(posedge clk) begin
		if (cmd.addr_load && !hit_c) begin
			if (is_free) begin
				rsp_q.result_frame <= '0;
				rsp_q.status       <= ST_REJECTED;
			end else if (dummy_vld_q) begin
				rsp_q.result_frame <= dummy_q;
				rsp_q.status       <= ST_DUMMY;
			end else begin
				rsp_q.result_frame <= '0;
				rsp_q.status       <= ST_EXHAUSTED;
			end
		end else if (cmd.wr_en) begin
			if (is_free) begin
				rsp_q.result_frame <= '0;
				rsp_q.status       <= ST_FREED;
			end else begin
				rsp_q.result_frame <= base_q + FRAME_W'({idx_q, lz});
				rsp_q.status       <= ST_ALLOCATED;
			end
		end
	end

	assign ram_we    = cmd.clr_we || cmd.wr_en;
	assign ram_waddr = cmd.clr_we ? clr_q : idx_q;
	assign ram_wdata = cmd.clr_we ? '0 : new_word;

	bpa_ram #(
		.WIDTH(BITS_PER_WORD),
		.DEPTH(MAX_WORDS)
	) u_bitmap (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd_en),
		.raddr (idx_q),
		.rdata (rd_word)
	);

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

>>> hdl/bitmap_page_allocator.sv
// Top level of the bitmap page allocator: controller, datapath and checks.
// Depends on bpa_pkg, bpa_ctrl, bpa_dp (and bpa_ram below it).
//
// Usage
//  Command channel: drive req (cmd, page_frame) and raise start; the beat is
//  taken at a rising edge with start high and busy low.  cmd alloc ignores
//  page_frame; cmd free releases that frame.
//  Result channel: exactly one result per command, on rsp for a single cycle
//  with done high.  The receiver cannot hold it off, so it must sample then.
//  Config channel: cfg_valid/cfg_ready with cfg_index and cfg_wdata; ready is
//  always high.  Write only while idle.  Index 0 words in use, 1 base frame,
//  2 dummy frame, 3 dummy valid.
//  Timing: an accepted beat that touches the bitmap passes S_ADDR (search or
//  range check), S_RD (RAM read) and S_WR (RAM write), and done is registered
//  out of S_WR; exhausted, dummy or rejected results are registered in S_ADDR.
//  busy drops in the done cycle, so no new command is taken before done.
//  A hint beyond a reduced word count first passes the one-bit-a-cycle modulo.
//  The word search is a single rotating priority encode over per-word full
//  flags; the cost per item is set by the RAM read-modify-write.
//  Reset: all config to reset values, hint to word 0, then a clearing pass
//  zeroes all MAX_WORDS words of the bitmap RAM with busy held high.
module bitmap_page_allocator
	import bpa_pkg::*;
#(
	parameter int unsigned MAX_WORDS = DEF_MAX_WORDS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  req_t                  req,
	output logic                  done,
	output rsp_t                  rsp,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [REG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata
);

	ctl_cmd_t ctl_cmd;
	dp_stat_t dp_stat;

	// config beats are always taken; the user must send them only while idle, the block does not enforce it
	assign cfg_ready = 1'b1;

	bpa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (ctl_cmd),
		.st     (dp_stat)
	);

	bpa_dp #(
		.MAX_WORDS(MAX_WORDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (ctl_cmd),
		.st        (dp_stat),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.done      (done),
		.rsp       (rsp)
	);

	// a result only ever ends a busy stretch
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result strobe without a command in flight");

	// no result in the cycle right after a command beat
	a_no_instant_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> !done)
		else $error("result appeared too early after a command");

	// only allocated and dummy results carry a frame
	a_frame_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_ALLOCATED && rsp.status != ST_DUMMY)
		|-> (rsp.result_frame == '0))
		else $error("non-zero frame on a status that carries none");

	// a controller RAM read is followed directly by its write-back, with no second read
	a_rw_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.rd_en |=> (ctl_cmd.wr_en && !ctl_cmd.rd_en))
		else $error("RAM read not followed by its write-back");

endmodule

>>> tb/bitmap_page_allocator_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for bitmap_page_allocator: directed and random alloc/free
// beats checked against a shadow bitmap model. Depends on bpa_pkg and the RTL only.
module bitmap_page_allocator_tb;
	import bpa_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	req_t                  req;
	logic                  done;
	rsp_t                  rsp;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [REG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	localparam logic [FRAME_W-1:0] FRAME_MAX = '1;

	// Shadow copy of the allocator: config registers, bitmap and next-fit hint.
	logic [WIU_W-1:0]         cfg_words;
	logic [FRAME_W-1:0]       cfg_base;
	logic [FRAME_W-1:0]       cfg_dummy;
	logic                     cfg_dummy_ok;
	logic [BITS_PER_WORD-1:0] shadow_bitmap [DEF_MAX_WORDS];
	logic [BIT_W-1:0]         shadow_hint;

	rsp_t expected_pages[$];  // one entry per accepted command beat, oldest first
	int   mismatches;
	bit   sender_idle;        // random gaps between command beats when set

	bitmap_page_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop: far beyond the slowest legal run (gaps, miss paths, modulo fix-up).
	initial begin
		#3_000_000;
		$display("bitmap_page_allocator_tb failed");
		$finish;
	end

	function automatic logic [FRAME_W-1:0] rand_frame();
		logic [63:0] t;
		t = {$urandom, $urandom};
		return t[FRAME_W-1:0];
	endfunction

	// Next-fit allocate / free on the shadow bitmap; returns the result beat owed.
	function automatic rsp_t compute_page_result(input cmd_e c, input logic [FRAME_W-1:0] f);
		rsp_t               r;
		int unsigned        n;
		int unsigned        first;
		int unsigned        w;
		int unsigned        b;
		int unsigned        k;
		logic [FRAME_W-1:0] off;
		r = '0;
		// counts above the pool size clamp to it
		n = (cfg_words > DEF_MAX_WORDS) ? DEF_MAX_WORDS : cfg_words;
		if (c == CMD_ALLOC) begin
			if (n != 0) begin
				// a hint left beyond a shrunk pool folds back by modulo
				first = shadow_hint % n;
				for (k = 0; k < n; k++) begin
					w = (first + k) % n;
					if (shadow_bitmap[w] != '1) begin
						b = 0;
						while (shadow_bitmap[w][b])
							b++;
						shadow_bitmap[w][b] = 1'b1;
						shadow_hint = BIT_W'(w);
						// frame number wraps at 52 bits
						r.result_frame = cfg_base + FRAME_W'(w * BITS_PER_WORD + b);
						r.status = ST_ALLOCATED;
						return r;
					end
				end
			end
			// pool full or empty: hint stays put
			if (cfg_dummy_ok) begin
				r.result_frame = cfg_dummy;
				r.status = ST_DUMMY;
			end else begin
				r.status = ST_EXHAUSTED;
			end
			return r;
		end
		if (f < cfg_base) begin
			r.status = ST_REJECTED;
			return r;
		end
		off = f - cfg_base;
		if ((off >> BIT_W) >= n) begin
			r.status = ST_REJECTED;
			return r;
		end
		// freeing an already free page still reports freed
		w = int'(off >> BIT_W);
		shadow_bitmap[w][off[BIT_W-1:0]] = 1'b0;
		r.status = ST_FREED;
		return r;
	endfunction

	// Result checker: done is a one-cycle strobe, so every edge with done high is a beat.
	always @(posedge clk) begin
		rsp_t want;
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (expected_pages.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: result beat with nothing owed: frame %h status %0d",
						$realtime, rsp.result_frame, rsp.status);
			end else begin
				want = expected_pages.pop_front();
				if (rsp.result_frame !== want.result_frame || rsp.status !== want.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: page result mismatch: expected frame %h status %0d, got frame %h status %0d",
							$realtime, want.result_frame, want.status,
							rsp.result_frame, rsp.status);
				end
			end
		end
	end

	// One command beat. start is left high on return so a zero gap runs back to back;
	// it is only lowered ahead of a gap or by settle.
	task automatic send_page_cmd(input cmd_e c, input logic [FRAME_W-1:0] f);
		int unsigned gap;
		gap = sender_idle ? $urandom_range(0, 19) : 0;
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req   <= req_t'{cmd: c, page_frame: f};
		start <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		expected_pages.push_back(compute_page_result(c, f));
	endtask

	// Hold off until every owed result is in, then allow for the slowest path
	// (RAM read-modify-write plus the bit-serial modulo).
	task automatic settle();
		start <= 1'b0;
		while (expected_pages.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	// Register write; only called while the block is idle.
	task automatic cfg_write(input reg_idx_e idx, input logic [CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		case (idx)
			REG_WORDS_IN_USE: cfg_words    = val[WIU_W-1:0];
			REG_BASE_FRAME:   cfg_base     = val[FRAME_W-1:0];
			REG_DUMMY_FRAME:  cfg_dummy    = val[FRAME_W-1:0];
			REG_DUMMY_VALID:  cfg_dummy_ok = val[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Upper data bits are junk on the narrow registers: only the low bits count.
	task automatic cfg_pool(input logic [WIU_W-1:0] words, input logic [FRAME_W-1:0] base,
			input logic [FRAME_W-1:0] dummy, input logic dummy_ok);
		logic [FRAME_W-1:0] junk;
		junk = rand_frame();
		cfg_write(REG_WORDS_IN_USE, {junk[FRAME_W-1:WIU_W], words});
		cfg_write(REG_BASE_FRAME, base);
		cfg_write(REG_DUMMY_FRAME, dummy);
		junk = rand_frame();
		cfg_write(REG_DUMMY_VALID, {junk[FRAME_W-1:1], dummy_ok});
	endtask

	// Reset values: 64 words from frame 0, no dummy. Alloc ignores page_frame.
	task automatic test_reset_defaults();
		send_page_cmd(CMD_ALLOC, FRAME_MAX);
		send_page_cmd(CMD_ALLOC, '0);
		send_page_cmd(CMD_ALLOC, rand_frame());
		send_page_cmd(CMD_FREE, 52'd1);
		send_page_cmd(CMD_ALLOC, '0);         // lowest zero bit again
		send_page_cmd(CMD_FREE, 52'd7);       // page never taken: double free
		send_page_cmd(CMD_FREE, 52'd4095);    // last page of the pool
		send_page_cmd(CMD_FREE, 52'd4096);    // one past the pool
		send_page_cmd(CMD_FREE, FRAME_MAX);
		settle();
	endtask

	// Word count above the limit acts as the full 64 words.
	task automatic test_oversized_pool();
		cfg_pool(7'd127, 52'd100, '0, 1'b0);
		send_page_cmd(CMD_FREE, 52'd99);      // below base
		send_page_cmd(CMD_FREE, 52'd100 + 52'd4095);
		send_page_cmd(CMD_FREE, 52'd100 + 52'd4096);
		send_page_cmd(CMD_ALLOC, FRAME_MAX);
		settle();
	endtask

	// Zero words: nothing to hand out, nothing to free.
	task automatic test_empty_pool();
		cfg_pool(7'd0, 52'd100, FRAME_MAX, 1'b0);
		send_page_cmd(CMD_ALLOC, '0);
		send_page_cmd(CMD_FREE, 52'd100);
		settle();
		cfg_write(REG_DUMMY_VALID, 52'd1);
		send_page_cmd(CMD_ALLOC, '0);
		settle();
	endtask

	// Pool based two frames short of the top: offsets past 1 wrap to low frames,
	// and those wrapped frames then sit below base on free.
	task automatic test_frame_wrap();
		cfg_pool(7'd1, FRAME_MAX - 52'd1, '0, 1'b0);
		send_page_cmd(CMD_ALLOC, '0);
		send_page_cmd(CMD_FREE, 52'd2);
		send_page_cmd(CMD_FREE, FRAME_MAX - 52'd1);
		send_page_cmd(CMD_ALLOC, '0);
		settle();
	endtask

	// Free target: mostly inside the pool, some just outside either end, some anywhere.
	function automatic logic [FRAME_W-1:0] pick_free_frame();
		int unsigned n;
		n = (cfg_words > DEF_MAX_WORDS) ? DEF_MAX_WORDS : cfg_words;
		case ($urandom_range(0, 9))
			0: return rand_frame();
			1: return cfg_base - 52'd1 - FRAME_W'($urandom_range(0, 63));
			2: return cfg_base + FRAME_W'(n * BITS_PER_WORD + $urandom_range(0, 63));
			default: return cfg_base + FRAME_W'($urandom_range(0, (n == 0) ? 0 : n * 64 - 1));
		endcase
	endfunction

	task automatic run_phase(input logic [WIU_W-1:0] words, input logic [FRAME_W-1:0] base,
			input logic [FRAME_W-1:0] dummy, input logic dummy_ok,
			input int unsigned beats, input int unsigned alloc_pct, input bit idle);
		settle();
		cfg_pool(words, base, dummy, dummy_ok);
		sender_idle = idle;
		repeat (beats) begin
			if ($urandom_range(0, 99) == 0)
				settle();                     // drain completely now and then
			if ($urandom_range(0, 99) < alloc_pct)
				send_page_cmd(CMD_ALLOC, rand_frame());
			else
				send_page_cmd(CMD_FREE, pick_free_frame());
		end
	endtask

	// Phases chosen so small pools fill up (dummy and exhausted), the hint climbs
	// and is then left stale by a smaller count, and the far words keep their bits.
	task automatic test_random_traffic();
		run_phase(7'd1,   '0,                 FRAME_MAX,    1'b1, 150, 60, 1'b1);
		run_phase(7'd3,   rand_frame(),       rand_frame(), 1'b0, 300, 80, 1'b1);
		run_phase(7'd2,   rand_frame(),       rand_frame(), 1'b1, 150, 60, 1'b0);
		run_phase(7'd64,  52'hF_FFFF_FFFF_F000, '0,         1'b0, 150, 55, 1'b1);
		run_phase(7'd5,   '0,                 rand_frame(), 1'b1, 150, 50, 1'b1);
		run_phase(7'd100, rand_frame(),       rand_frame(), 1'b0, 100, 60, 1'b0);
		run_phase(7'd0,   rand_frame(),       FRAME_MAX,    1'b1,  30, 50, 1'b1);
		run_phase(7'd4,   52'd64,             rand_frame(), 1'b0, 170, 65, 1'b1);
		settle();
	endtask

	initial begin
		arst_n    <= 1'b0;
		start     <= 1'b0;
		req       <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= REG_WORDS_IN_USE;
		cfg_wdata <= '0;
		mismatches   = 0;
		sender_idle  = 1'b1;
		cfg_words    = WIU_RESET;
		cfg_base     = '0;
		cfg_dummy    = '0;
		cfg_dummy_ok = 1'b0;
		shadow_hint  = '0;
		foreach (shadow_bitmap[i])
			shadow_bitmap[i] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		// bitmap clearing pass runs with busy high
		do @(posedge clk); while (busy !== 1'b0);

		test_reset_defaults();
		test_oversized_pool();
		test_empty_pool();
		test_frame_wrap();
		test_random_traffic();

		if (mismatches == 0)
			$display("bitmap_page_allocator_tb passed");
		else
			$display("bitmap_page_allocator_tb failed");
		$finish;
	end

endmodule

>>> sim.f
hdl/bpa_pkg.sv
hdl/bpa_ram.sv
hdl/bpa_ctrl.sv
hdl/bpa_dp.sv
hdl/bitmap_page_allocator.sv
tb/bitmap_page_allocator_tb.sv
